// ----- src/reliable_message_ack_tracker_macros.svh -----
// Assertion macros for the message acknowledgement tracker.
`ifndef RELIABLE_MESSAGE_ACK_TRACKER_MACROS_SVH
`define RELIABLE_MESSAGE_ACK_TRACKER_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RMAT_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define RMAT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

// ----- src/rmat_pkg.sv -----
// Shared types, codes and defaults of the message acknowledgement tracker.
package rmat_pkg;
  localparam int unsigned TableSlotsDef = 16;
  localparam int unsigned SeenDepthDef = 64;
  localparam logic [7:0] TimeoutReset = 8'd2;

  typedef enum logic [1:0] {
    REQ_SEND = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_DATA = 2'd2,
    REQ_TICK = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ACT_TRANSMIT   = 4'd0,
    ACT_RETRANSMIT = 4'd1,
    ACT_TABLE_FULL = 4'd2,
    ACT_ACK_MATCH  = 4'd3,
    ACT_ACK_UNKNOWN = 4'd4,
    ACT_DELIVER    = 4'd5,
    ACT_DUPLICATE  = 4'd6,
    ACT_STORE_FULL = 4'd7,
    ACT_TICK_DONE  = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_SEEN_RD,
    ST_SEEN_CMP,
    ST_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the request
    logic slot_step; // evaluate the current slot
    logic slot_next; // advance the slot index
    logic seen_rd;   // issue a seen-store read
    logic seen_next; // advance the seen index
    logic finish;    // emit the closing result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic slot_last;  // current slot is the last one
    logic slot_hit;   // send/ack found its slot (ends the scan)
    logic seen_end;   // seen index has reached the fill count
    logic seen_hit;   // registered read data matches
  } status_t;
endpackage

// ----- src/rmat_ctrl.sv -----
// Controller state machine of the message acknowledgement tracker.
module rmat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rmat_pkg::req_e    req_i,
  input  rmat_pkg::status_t sts_i,
  output logic              busy_o,
  output rmat_pkg::cmd_t    cmd_o
);
  import rmat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = (req_i == REQ_DATA) ? ST_SEEN_RD : ST_SLOT;
        end
      end
      ST_SLOT: begin
        cmd_o.slot_step = 1'b1;
        if (sts_i.slot_hit || sts_i.slot_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.slot_next = 1'b1;
        end
      end
      ST_SEEN_RD: begin
        if (sts_i.seen_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.seen_rd = 1'b1;
          state_d = ST_SEEN_CMP;
        end
      end
      ST_SEEN_CMP: begin
        if (sts_i.seen_hit) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.seen_next = 1'b1;
          state_d = ST_SEEN_RD;
        end
      end
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ----- src/rmat_dp.sv -----
// Datapath of the message acknowledgement tracker: slot table, seen store, counters.
module rmat_dp #(
  parameter int unsigned TableSlots = rmat_pkg::TableSlotsDef,
  parameter int unsigned SeenDepth = rmat_pkg::SeenDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmat_pkg::cmd_t     cmd_i,
  input  rmat_pkg::req_e     req_i,
  input  logic [15:0]        seq_in_i,
  input  logic [7:0]         handle_i,
  input  logic [7:0]         timeout_i,
  output rmat_pkg::status_t  sts_o,
  output logic               strobe_o,
  output logic [3:0]         action_o,
  output logic [15:0]        seq_out_o,
  output logic [7:0]         handle_out_o,
  output logic               last_o
);
  import rmat_pkg::*;

  localparam int unsigned SlotW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned SeenW = (SeenDepth > 1) ? $clog2(SeenDepth) : 1;
  localparam int unsigned CntW = $clog2(SeenDepth + 1);

  logic [TableSlots-1:0] valid_q;
  logic [15:0] slot_seq_q [TableSlots];
  logic [7:0]  slot_hdl_q [TableSlots];
  logic [15:0] slot_stamp_q [TableSlots];
  logic [15:0] seen_mem [SeenDepth];
  logic [15:0] seen_rd_q;

  req_e        req_q;
  logic [15:0] seq_q;
  logic [7:0]  hdl_q;
  logic [SlotW-1:0] slot_idx_q;
  logic [CntW-1:0]  seen_idx_q, seen_cnt_q;
  logic [15:0] next_seq_q, now_q;
  logic        hit_q;

  logic [15:0] age;
  logic        cur_valid, slot_hit, tick_fire;
  assign cur_valid = valid_q[slot_idx_q];
  assign age = now_q - slot_stamp_q[slot_idx_q];
  assign tick_fire = cur_valid && (age >= {8'd0, timeout_i});
  always_comb begin
    case (req_q)
      REQ_SEND: slot_hit = !cur_valid;
      REQ_ACK:  slot_hit = cur_valid && (slot_seq_q[slot_idx_q] == seq_q);
      default:  slot_hit = 1'b0;
    endcase
  end

  assign sts_o.slot_last = (32'(slot_idx_q) == TableSlots - 1);
  assign sts_o.slot_hit = slot_hit;
  assign sts_o.seen_end = (seen_idx_q == seen_cnt_q);
  assign sts_o.seen_hit = (seen_rd_q == seq_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      seq_q <= seq_in_i;
      hdl_q <= handle_i;
    end
    if (cmd_i.seen_rd) begin
      seen_rd_q <= seen_mem[seen_idx_q[SeenW-1:0]];
    end
    if (cmd_i.finish && req_q == REQ_DATA && !hit_q && seen_cnt_q != CntW'(SeenDepth)) begin
      seen_mem[seen_cnt_q[SeenW-1:0]] <= seq_q;
    end
    if (cmd_i.slot_step && req_q == REQ_SEND && slot_hit) begin
      slot_seq_q[slot_idx_q] <= next_seq_q;
      slot_hdl_q[slot_idx_q] <= hdl_q;
      slot_stamp_q[slot_idx_q] <= now_q;
    end
    if (cmd_i.slot_step && req_q == REQ_TICK && tick_fire) begin
      slot_stamp_q[slot_idx_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      req_q <= REQ_SEND;
      slot_idx_q <= '0;
      seen_idx_q <= '0;
      seen_cnt_q <= '0;
      next_seq_q <= '0;
      now_q <= '0;
      hit_q <= 1'b0;
      strobe_o <= 1'b0;
      action_o <= '0;
      seq_out_o <= '0;
      handle_out_o <= '0;
      last_o <= 1'b0;
    end else begin
      strobe_o <= (cmd_i.slot_step && req_q == REQ_TICK && tick_fire) || cmd_i.finish;
      if (cmd_i.load) begin
        req_q <= req_e'(req_i);
        slot_idx_q <= '0;
        seen_idx_q <= '0;
        hit_q <= 1'b0;
        if (req_i == REQ_TICK) begin
          now_q <= now_q + 16'd1;
        end
      end
      if (cmd_i.slot_next) begin
        slot_idx_q <= slot_idx_q + SlotW'(1);
      end
      if (cmd_i.seen_next) begin
        seen_idx_q <= seen_idx_q + CntW'(1);
      end
      if (cmd_i.slot_step && slot_hit) begin
        hit_q <= 1'b1;
        if (req_q == REQ_SEND) begin
          valid_q[slot_idx_q] <= 1'b1;
          next_seq_q <= next_seq_q + 16'd1;
        end else begin
          valid_q[slot_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.slot_step && req_q == REQ_TICK && tick_fire) begin
        action_o <= ACT_RETRANSMIT;
        seq_out_o <= slot_seq_q[slot_idx_q];
        handle_out_o <= slot_hdl_q[slot_idx_q];
        last_o <= 1'b0;
      end
      if (!cmd_i.seen_rd && !cmd_i.load && !cmd_i.slot_step && sts_o.seen_hit
          && !cmd_i.seen_next && !cmd_i.finish && req_q == REQ_DATA) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        last_o <= 1'b1;
        case (req_q)
          REQ_SEND: begin
            if (hit_q) begin
              action_o <= ACT_TRANSMIT;
              seq_out_o <= next_seq_q - 16'd1;
              handle_out_o <= hdl_q;
            end else begin
              action_o <= ACT_TABLE_FULL;
              seq_out_o <= '0;
              handle_out_o <= '0;
            end
          end
          REQ_ACK: begin
            action_o <= hit_q ? ACT_ACK_MATCH : ACT_ACK_UNKNOWN;
            seq_out_o <= seq_q;
            handle_out_o <= '0;
          end
          REQ_DATA: begin
            seq_out_o <= seq_q;
            handle_out_o <= '0;
            if (hit_q) begin
              action_o <= ACT_DUPLICATE;
            end else if (seen_cnt_q == CntW'(SeenDepth)) begin
              action_o <= ACT_STORE_FULL;
            end else begin
              action_o <= ACT_DELIVER;
              seen_cnt_q <= seen_cnt_q + CntW'(1);
            end
          end
          default: begin
            action_o <= ACT_TICK_DONE;
            seq_out_o <= '0;
            handle_out_o <= '0;
          end
        endcase
      end
    end
  end
endmodule

// ----- src/reliable_message_ack_tracker.sv -----
// Top level of the message acknowledgement tracker.
// A request is taken when start is high and busy is low; busy falls in the
// cycle in which the request's last result is shown, so the next request can
// be taken at the edge that ends that cycle. Results come out one per beat on
// result_valid_o and are never held off: the receiver must take each beat in
// the cycle it appears. A send or ack walks the slot table one slot per cycle
// and stops at the first free or matching slot. A tick walks every slot, one
// per cycle, emitting a retransmit beat for each aged slot, then a tick-done
// beat. A data frame reads the seen store one entry at a time, each read
// registered and then compared (one memory read port). The timeout register
// is written through its own valid/ready channel, which is ready only while
// idle.
module reliable_message_ack_tracker #(
  parameter int unsigned TABLE_SLOTS = rmat_pkg::TableSlotsDef,
  parameter int unsigned SEEN_DEPTH = rmat_pkg::SeenDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] seq_in_i,
  input  logic [7:0]  msg_handle_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [3:0]  action_o,
  output logic [15:0] seq_out_o,
  output logic [7:0]  handle_out_o,
  output logic        last_o
);
  import rmat_pkg::*;

  cmd_t    cmd;
  status_t sts;
  req_e    req;
  logic [7:0] timeout_q;

  assign req = req_e'(req_type_i);
  assign cfg_ready_o = !busy;

  // The timeout register only changes while the block is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  rmat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (req),
    .sts_i  (sts),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  rmat_dp #(
    .TableSlots(TABLE_SLOTS),
    .SeenDepth (SEEN_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req),
    .seq_in_i    (seq_in_i),
    .handle_i    (msg_handle_i),
    .timeout_i   (timeout_q),
    .sts_o       (sts),
    .strobe_o    (result_valid_o),
    .action_o    (action_o),
    .seq_out_o   (seq_out_o),
    .handle_out_o(handle_out_o),
    .last_o      (last_o)
  );

`include "reliable_message_ack_tracker_macros.svh"

  // A closing beat is shown while the block is already idle.
  `RMAT_ASSERT_IMP(a_last_idle, result_valid_o && last_o, !busy)
  // A beat that is not a closing beat only appears while busy, with a request in flight.
  `RMAT_ASSERT_IMP(a_beat_busy, result_valid_o && !last_o, busy)
  // An accepted request makes the block busy.
  `RMAT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
endmodule
